// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define LFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define LFM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/lfm_pkg.sv
package lfm_pkg;

  localparam int CH_W      = 6;
  localparam int MV_W      = 12;
  localparam int GAIN_W    = 16;
  localparam int FBIT_W    = 5;
  localparam int CODE_W    = 8;
  localparam int TICK_W    = 16;
  localparam int VAL_W     = 16;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int PROD_W    = MV_W + GAIN_W;

  localparam logic [CFG_W-1:0] RANGE_LOW_RST  = 16'd0;
  localparam logic [CFG_W-1:0] RANGE_HIGH_RST = 16'hFFFF;
  localparam logic [CFG_W-1:0] HOLD_TICKS_RST = 16'd300;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_LOW  = 2'd0,
    CFG_RANGE_HIGH = 2'd1,
    CFG_HOLD_TICKS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [FBIT_W-1:0] fbit;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] range_low;
    logic [CFG_W-1:0] range_high;
    logic [CFG_W-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic              sample;
    logic [PROD_W-1:0] prod;
    logic [TICK_W-1:0] timer;
    logic [TICK_W-1:0] now;
    logic [FBIT_W-1:0] fbit;
    logic [CODE_W-1:0] code;
    cfg_t              cfg;
    logic [WORD_W-1:0] sticky;
    logic [CODE_W-1:0] rcode;
    logic [VAL_W-1:0]  rval;
  } chk_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  scaled;
    logic              fault_now;
    logic              tmr_we;
    logic [TICK_W-1:0] timer_next;
    logic [WORD_W-1:0] sticky;
    logic [CODE_W-1:0] rcode;
    logic [VAL_W-1:0]  rval;
  } chk_rsp_t;

endpackage

// File: design/lfm_in_if.sv
interface lfm_in_if;
  import lfm_pkg::*;

  logic              valid;
  logic              ready;
  op_e               opcode;
  logic [CH_W-1:0]   channel;
  logic [MV_W-1:0]   millivolts;
  logic [TICK_W-1:0] now_tick;
  logic [GAIN_W-1:0] gain;
  logic [FBIT_W-1:0] fault_bit;
  logic [CODE_W-1:0] error_code;

  modport source (
    output valid, opcode, channel, millivolts, now_tick, gain, fault_bit, error_code,
    input  ready
  );

  modport sink (
    input  valid, opcode, channel, millivolts, now_tick, gain, fault_bit, error_code,
    output ready
  );

endinterface

// File: design/lfm_out_if.sv
interface lfm_out_if;
  import lfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  scaled_value;
  logic              fault_now;
  logic [WORD_W-1:0] fault_word;
  logic [CODE_W-1:0] last_error_code;
  logic [VAL_W-1:0]  last_error_value;

  modport source (
    output valid, scaled_value, fault_now, fault_word, last_error_code, last_error_value,
    input  ready
  );

  modport sink (
    input  valid, scaled_value, fault_now, fault_word, last_error_code, last_error_value,
    output ready
  );

endinterface

// File: design/lfm_ram.sv
module lfm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lfm_check.sv
module lfm_check #(
  parameter int GAIN_FRACTION_BITS = 10
) (
  input  lfm_pkg::chk_req_t req_i,
  output lfm_pkg::chk_rsp_t rsp_o
);
  import lfm_pkg::*;

  logic [PROD_W-1:0] quot;
  logic [VAL_W-1:0]  val;
  logic              out_of_range;
  logic [TICK_W-1:0] elapsed;

  always_comb begin
    quot         = req_i.prod >> GAIN_FRACTION_BITS;
    val          = (|quot[PROD_W-1:VAL_W]) ? {VAL_W{1'b1}} : quot[VAL_W-1:0];
    out_of_range = (val > req_i.cfg.range_high) || (val < req_i.cfg.range_low);
    elapsed      = req_i.now - req_i.timer;

    rsp_o            = '0;
    rsp_o.sticky     = req_i.sticky;
    rsp_o.rcode      = req_i.rcode;
    rsp_o.rval       = req_i.rval;
    if (req_i.sample) begin
      rsp_o.scaled = val;
      rsp_o.tmr_we = 1'b1;
      if (out_of_range) begin
        if (req_i.timer == '0) begin
          rsp_o.timer_next = req_i.now;
        end else begin
          rsp_o.timer_next = req_i.timer;
          if (elapsed > req_i.cfg.hold_ticks) begin
            rsp_o.sticky    = req_i.sticky | (WORD_W'(1) << req_i.fbit);
            rsp_o.rcode     = req_i.code;
            rsp_o.rval      = val;
            rsp_o.fault_now = 1'b1;
          end
        end
      end else begin
        rsp_o.timer_next = '0;
      end
    end
  end

endmodule

// File: design/multichannel_limit_fault_monitor.sv
// Pipeline: a request passes the first-stage, second-stage and output registers.
// Throughput: one request per cycle unless the output stalls; each channel
// memory takes one read and one write per cycle; timer updates to the same
// channel are forwarded. Reset: asynchronous; clears the pipeline, the fault word,
// the recorded code and value and the timer valid bits, and loads the register
// defaults. The channel table holds nothing until loaded and is not swept.
`include "assert_macros.svh"

module multichannel_limit_fault_monitor #(
  parameter int CHANNELS           = 64,
  parameter int GAIN_FRACTION_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lfm_in_if.sink                        in_i,
  lfm_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [lfm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lfm_pkg::CFG_W-1:0]     cfg_data_i
);
  import lfm_pkg::*;

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHK_W = 9;

  cfg_t cfg_q;

  logic out_free, s2_can, s1_can, s2_go, s1_go, in_acc;
  logic ch_ok_in;
  logic [AW-1:0] in_addr;

  logic s1_v_q, s1_byp_q;
  logic s1_sample_q, s1_tvld_q;
  logic [AW-1:0] s1_addr_q;
  logic [MV_W-1:0] s1_mv_q;
  logic [TICK_W-1:0] s1_now_q, s1_bypd_q, s1_timer;
  logic [PROD_W-1:0] s1_prod;

  logic s2_v_q, s2_sample_q;
  logic [AW-1:0] s2_addr_q;
  logic [PROD_W-1:0] s2_prod_q;
  logic [TICK_W-1:0] s2_now_q, s2_timer_q;
  logic [FBIT_W-1:0] s2_fbit_q;
  logic [CODE_W-1:0] s2_code_q;

  logic [CHANNELS-1:0] tvld_q;
  logic [WORD_W-1:0] sticky_q;
  logic [CODE_W-1:0] rcode_q;
  logic [VAL_W-1:0] rval_q;

  logic out_v_q;
  logic [VAL_W-1:0] o_scaled_q, o_value_q;
  logic o_fault_q;
  logic [WORD_W-1:0] o_word_q;
  logic [CODE_W-1:0] o_code_q;

  entry_t tbl_wdata, tbl_rdata;
  logic [TICK_W-1:0] tmr_rdata;
  logic tmr_we;
  chk_req_t chk_req;
  chk_rsp_t chk_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low  <= RANGE_LOW_RST;
      cfg_q.range_high <= RANGE_HIGH_RST;
      cfg_q.hold_ticks <= HOLD_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RANGE_LOW:  cfg_q.range_low  <= cfg_data_i;
        CFG_RANGE_HIGH: cfg_q.range_high <= cfg_data_i;
        CFG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_v_q || out_o.ready;
  assign s2_go      = s2_v_q && out_free;
  assign s2_can     = !s2_v_q || out_free;
  assign s1_go      = s1_v_q && s2_can;
  assign s1_can     = !s1_v_q || s2_can;
  assign in_i.ready = s1_can;
  assign in_acc     = in_i.valid && s1_can;

  assign ch_ok_in = CHK_W'(in_i.channel) < CHK_W'(CHANNELS);
  assign in_addr  = AW'(in_i.channel);

  assign tbl_wdata.gain = in_i.gain;
  assign tbl_wdata.fbit = in_i.fault_bit;
  assign tbl_wdata.code = in_i.error_code;

  lfm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_i.opcode == OP_LOAD) && ch_ok_in),
    .waddr_i (in_addr),
    .wdata_i (tbl_wdata),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (tbl_rdata)
  );

  assign tmr_we = s2_go && chk_rsp.tmr_we;

  lfm_ram #(
    .WIDTH (TICK_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_tmr_ram (
    .clk_i   (clk_i),
    .we_i    (tmr_we),
    .waddr_i (s2_addr_q),
    .wdata_i (chk_rsp.timer_next),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (tmr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_byp_q <= 1'b0;
      s2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      tvld_q   <= '0;
      sticky_q <= '0;
      rcode_q  <= '0;
      rval_q   <= '0;
    end else begin
      if (s1_can) begin
        s1_v_q   <= in_i.valid;
        s1_byp_q <= in_i.valid && tmr_we && (s2_addr_q == in_addr);
      end
      if (s2_can) begin
        s2_v_q <= s1_v_q;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
      if (tmr_we) begin
        tvld_q[s2_addr_q] <= 1'b1;
      end
      if (s2_go) begin
        sticky_q <= chk_rsp.sticky;
        rcode_q  <= chk_rsp.rcode;
        rval_q   <= chk_rsp.rval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= (in_i.opcode == OP_SAMPLE) && ch_ok_in;
      s1_addr_q   <= in_addr;
      s1_mv_q     <= in_i.millivolts;
      s1_now_q    <= in_i.now_tick;
      s1_tvld_q   <= tvld_q[in_addr];
      s1_bypd_q   <= chk_rsp.timer_next;
    end
  end

  assign s1_timer = s1_byp_q ? s1_bypd_q : (s1_tvld_q ? tmr_rdata : '0);
  assign s1_prod  = PROD_W'(s1_mv_q) * PROD_W'(tbl_rdata.gain);

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_sample_q <= s1_sample_q;
      s2_addr_q   <= s1_addr_q;
      s2_prod_q   <= s1_prod;
      s2_now_q    <= s1_now_q;
      s2_fbit_q   <= tbl_rdata.fbit;
      s2_code_q   <= tbl_rdata.code;
      s2_timer_q  <= (tmr_we && (s2_addr_q == s1_addr_q)) ? chk_rsp.timer_next : s1_timer;
    end
  end

  always_comb begin
    chk_req.sample = s2_sample_q;
    chk_req.prod   = s2_prod_q;
    chk_req.timer  = s2_timer_q;
    chk_req.now    = s2_now_q;
    chk_req.fbit   = s2_fbit_q;
    chk_req.code   = s2_code_q;
    chk_req.cfg    = cfg_q;
    chk_req.sticky = sticky_q;
    chk_req.rcode  = rcode_q;
    chk_req.rval   = rval_q;
  end

  lfm_check #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_check (
    .req_i (chk_req),
    .rsp_o (chk_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      o_scaled_q <= chk_rsp.scaled;
      o_fault_q  <= chk_rsp.fault_now;
      o_word_q   <= chk_rsp.sticky;
      o_code_q   <= chk_rsp.rcode;
      o_value_q  <= chk_rsp.rval;
    end
  end

  assign out_o.valid            = out_v_q;
  assign out_o.scaled_value     = o_scaled_q;
  assign out_o.fault_now        = o_fault_q;
  assign out_o.fault_word       = o_word_q;
  assign out_o.last_error_code  = o_code_q;
  assign out_o.last_error_value = o_value_q;

  `LFM_ASSERT(a_fault_sets_word, out_o.valid && out_o.fault_now |-> out_o.fault_word != '0, "fault reported with an empty fault word")
  `LFM_ASSERT(a_sticky_keeps, 1'b1 |=> ((sticky_q & $past(sticky_q)) == $past(sticky_q)), "fault word lost a bit")
  `LFM_ASSERT(a_bypass_live, s1_byp_q |-> s1_v_q, "timer bypass held without a request in the first stage")
  `LFM_ASSERT_RST(a_reset_idle, !rst_ni |-> !out_o.valid, "result valid during reset")

endmodule

// File: bench/multichannel_limit_fault_monitor_tb.sv
`timescale 1ns / 100ps

module multichannel_limit_fault_monitor_tb;
  import lfm_pkg::*;

  localparam int CHANNELS     = 64;
  localparam int FRAC_BITS    = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    op_e               op;
    logic [CH_W-1:0]   ch;
    logic [MV_W-1:0]   mv;
    logic [TICK_W-1:0] tick;
    logic [GAIN_W-1:0] gain;
    logic [FBIT_W-1:0] fbit;
    logic [CODE_W-1:0] code;
  } sensor_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  scaled;
    logic              fault_now;
    logic [WORD_W-1:0] word;
    logic [CODE_W-1:0] code;
    logic [VAL_W-1:0]  value;
  } fault_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  lfm_in_if  req_if ();
  lfm_out_if rsp_if ();

  multichannel_limit_fault_monitor #(
    .CHANNELS          (CHANNELS),
    .GAIN_FRACTION_BITS(FRAC_BITS)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (req_if),
    .out_o     (rsp_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the monitor state.
  logic [GAIN_W-1:0] gain_mem    [CHANNELS];
  logic [FBIT_W-1:0] fbit_mem    [CHANNELS];
  logic [CODE_W-1:0] code_mem    [CHANNELS];
  logic [TICK_W-1:0] timer_start [CHANNELS] = '{default: '0};
  logic [WORD_W-1:0] sticky_word = '0;
  logic [CODE_W-1:0] rec_code    = '0;
  logic [VAL_W-1:0]  rec_value   = '0;
  logic [CFG_W-1:0]  lim_low     = RANGE_LOW_RST;
  logic [CFG_W-1:0]  lim_high    = RANGE_HIGH_RST;
  logic [CFG_W-1:0]  hold_len    = HOLD_TICKS_RST;

  sensor_req_t   queued_requests [$];
  fault_report_t predicted_reports [$];
  sensor_req_t   active_req;

  int src_idle_pct = 27;
  int snk_idle_pct = 64;

  int unsigned n_accepted   = 0;
  int unsigned n_loads      = 0;
  int unsigned n_reports    = 0;
  int unsigned n_faults     = 0;
  int unsigned n_settings   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cnt    = 0;

  // Stimulus bookkeeping.
  bit                chan_loaded [CHANNELS];
  logic [CH_W-1:0]   loaded_list [$];
  logic [TICK_W-1:0] stim_tick = '0;
  int unsigned       tick_step_max = 170;

  task automatic update_fault_model(input sensor_req_t r);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    logic [TICK_W-1:0] elapsed;
    fault_report_t     rsp;
    rsp.scaled    = '0;
    rsp.fault_now = 1'b0;
    if (r.ch < CHANNELS) begin
      if (r.op == OP_LOAD) begin
        gain_mem[r.ch] = r.gain;
        fbit_mem[r.ch] = r.fbit;
        code_mem[r.ch] = r.code;
      end else begin
        prod = PROD_W'(r.mv) * PROD_W'(gain_mem[r.ch]);
        quot = prod >> FRAC_BITS;
        rsp.scaled = (quot > PROD_W'({VAL_W{1'b1}})) ? {VAL_W{1'b1}} : quot[VAL_W-1:0];
        if (rsp.scaled > lim_high || rsp.scaled < lim_low) begin
          if (timer_start[r.ch] == '0) begin
            timer_start[r.ch] = r.tick;
          end else begin
            elapsed = r.tick - timer_start[r.ch];
            if (elapsed > hold_len) begin
              sticky_word[fbit_mem[r.ch]] = 1'b1;
              rec_code      = code_mem[r.ch];
              rec_value     = rsp.scaled;
              rsp.fault_now = 1'b1;
            end
          end
        end else begin
          timer_start[r.ch] = '0;
        end
      end
    end
    rsp.word  = sticky_word;
    rsp.code  = rec_code;
    rsp.value = rec_value;
    predicted_reports.push_back(rsp);
  endtask

  task automatic check_report();
    fault_report_t exp;
    n_reports++;
    if (rsp_if.fault_now) n_faults++;
    if (predicted_reports.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("Unexpected report: scaled=%0d fault=%0b word=%h code=%h value=%0d",
                 rsp_if.scaled_value, rsp_if.fault_now, rsp_if.fault_word,
                 rsp_if.last_error_code, rsp_if.last_error_value);
    end else begin
      exp = predicted_reports.pop_front();
      if (rsp_if.scaled_value !== exp.scaled || rsp_if.fault_now !== exp.fault_now ||
          rsp_if.fault_word !== exp.word || rsp_if.last_error_code !== exp.code ||
          rsp_if.last_error_value !== exp.value) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("Report %0d mismatch: expected scaled=%0d fault=%0b word=%h code=%h value=%0d",
                   n_reports, exp.scaled, exp.fault_now, exp.word, exp.code, exp.value);
          $display("  got scaled=%0d fault=%0b word=%h code=%h value=%0d",
                   rsp_if.scaled_value, rsp_if.fault_now, rsp_if.fault_word,
                   rsp_if.last_error_code, rsp_if.last_error_value);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        update_fault_model(active_req);
        n_accepted++;
        if (active_req.op == OP_LOAD) n_loads++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (queued_requests.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          active_req = queued_requests.pop_front();
          req_if.valid      <= 1'b1;
          req_if.opcode     <= active_req.op;
          req_if.channel    <= active_req.ch;
          req_if.millivolts <= active_req.mv;
          req_if.now_tick   <= active_req.tick;
          req_if.gain       <= active_req.gain;
          req_if.fault_bit  <= active_req.fbit;
          req_if.error_code <= active_req.code;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_report();
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("Timeout: no request or report moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RANGE_LOW:  lim_low  = val;
      CFG_RANGE_HIGH: lim_high = val;
      CFG_HOLD_TICKS: hold_len = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || req_if.valid || predicted_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_load(input logic [CH_W-1:0] ch, input logic [GAIN_W-1:0] gain,
                           input logic [FBIT_W-1:0] fbit, input logic [CODE_W-1:0] code);
    sensor_req_t r;
    r.op   = OP_LOAD;
    r.ch   = ch;
    r.mv   = MV_W'($urandom);
    r.tick = TICK_W'($urandom);
    r.gain = gain;
    r.fbit = fbit;
    r.code = code;
    queued_requests.push_back(r);
    if (!chan_loaded[ch]) begin
      chan_loaded[ch] = 1'b1;
      loaded_list.push_back(ch);
    end
  endtask

  task automatic push_sample(input logic [CH_W-1:0] ch, input logic [MV_W-1:0] mv,
                             input logic [TICK_W-1:0] tick);
    sensor_req_t r;
    r.op   = OP_SAMPLE;
    r.ch   = ch;
    r.mv   = mv;
    r.tick = tick;
    r.gain = GAIN_W'($urandom);
    r.fbit = FBIT_W'($urandom);
    r.code = CODE_W'($urandom);
    queued_requests.push_back(r);
  endtask

  function automatic logic [CH_W-1:0] pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  task automatic queue_random_mix(input int count);
    int              made;
    int              kind;
    int              len;
    logic [CH_W-1:0] ch;
    logic [MV_W-1:0] mv;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(99);
      if (kind < 10 || loaded_list.size() == 0) begin
        push_load(CH_W'($urandom),
                  $urandom_range(1) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 4096)),
                  FBIT_W'($urandom), CODE_W'($urandom));
        made++;
      end else if (kind < 80) begin
        // A run of samples on one channel that mostly keeps its range status.
        ch  = pick_loaded();
        mv  = MV_W'($urandom);
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(19) == 0) stim_tick = TICK_W'($urandom);
          else stim_tick = stim_tick + TICK_W'($urandom_range(0, tick_step_max));
          if ($urandom_range(49) == 0) stim_tick = '0;
          push_sample(ch, mv ^ MV_W'($urandom_range(0, 3)), stim_tick);
        end
        made += len;
      end else begin
        push_sample(pick_loaded(), MV_W'($urandom), TICK_W'($urandom));
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] high,
                           input logic [CFG_W-1:0] hold, input int src_pct,
                           input int snk_pct, input int count);
    wait_idle();
    write_reg(CFG_RANGE_LOW, low);
    write_reg(CFG_RANGE_HIGH, high);
    write_reg(CFG_HOLD_TICKS, hold);
    n_settings++;
    src_idle_pct  = src_pct;
    snk_idle_pct  = snk_pct;
    tick_step_max = hold / 2 + 20;
    queue_random_mix(count);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_RANGE_LOW;
    cfg_data_i        = '0;
    req_if.valid      = 1'b0;
    req_if.opcode     = OP_SAMPLE;
    req_if.channel    = '0;
    req_if.millivolts = '0;
    req_if.now_tick   = '0;
    req_if.gain       = '0;
    req_if.fault_bit  = '0;
    req_if.error_code = '0;
    rsp_if.ready      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: everything is in range, including the saturated value.
    n_settings++;
    push_load(6'd0, 16'd0, 5'd0, 8'h00);
    push_load(6'd63, 16'hFFFF, 5'd31, 8'hFF);
    push_load(6'd42, 16'd1024, 5'd7, 8'h5A);
    push_sample(6'd0, 12'd4095, 16'd0);
    push_sample(6'd63, 12'd4095, 16'hFFFF);
    push_sample(6'd63, 12'd0, 16'd1);
    push_sample(6'd42, 12'd4095, 16'd2);
    push_sample(6'd42, 12'd1, 16'd3);
    wait_idle();

    write_reg(CFG_RANGE_LOW, 16'd1000);
    write_reg(CFG_RANGE_HIGH, 16'd40000);
    write_reg(CFG_HOLD_TICKS, 16'd300);
    write_reg(CFG_SPARE_IDX, 16'h1234);
    n_settings++;
    // A start stamp of zero leaves the timer idle; exact hold time does not fault.
    push_sample(6'd42, 12'd100, 16'd0);
    push_sample(6'd42, 12'd100, 16'd500);
    push_sample(6'd42, 12'd999, 16'd800);
    push_sample(6'd42, 12'd100, 16'd801);
    push_load(6'd21, 16'd10240, 5'd0, 8'h01);
    push_sample(6'd42, 12'd1000, 16'd900);
    push_sample(6'd21, 12'd4000, 16'd100);
    push_sample(6'd21, 12'd4001, 16'd65500);
    push_sample(6'd21, 12'd4095, 16'd300);
    push_sample(6'd63, 12'd4095, 16'd5);
    push_sample(6'd63, 12'd4095, 16'd306);
    push_sample(6'd0, 12'd4095, 16'd7);
    push_sample(6'd0, 12'd0, 16'd7);
    push_load(6'd42, 16'd512, 5'd15, 8'hA5);
    push_sample(6'd42, 12'd1, 16'd950);

    run_phase(16'd1000, 16'd40000, 16'd300, 27, 64, 255);
    run_phase(16'd0, 16'd3000, 16'd0, 27, 64, 255);
    run_phase(16'd20000, 16'hFFFF, 16'hFFFF, 64, 27, 255);
    run_phase(16'hFFFF, 16'd0, 16'd100, 64, 27, 255);
    run_phase(16'd500, 16'd8000, 16'd1000, 0, 0, 255);
    run_phase(16'hFFFF, 16'hFFFF, 16'd1, 0, 0, 255);
    wait_idle();

    $display("Covered %0d requests (%0d table loads) and %0d reports with %0d faults,",
             n_accepted, n_loads, n_reports, n_faults);
    $display("over %0d limit settings and three flow-control patterns; %0d mismatches.",
             n_settings, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
